/* sv/fcsg_pkg.sv */
`default_nettype none
package fcsg_pkg;

    localparam int PHASE_BITS_DEF = 32;
    localparam int WAVE_STEPS     = 32;
    localparam int WAVE_IW        = $clog2(WAVE_STEPS);
    localparam int REG_COUNT      = 18;
    localparam int REG_IW         = 5;
    localparam int DIV_W          = 27;   // (2048-f)*44100 < 2^27
    localparam int TIMER_W        = 34;
    localparam int INC_W          = 29;
    localparam int LEN_W          = 17;
    localparam int ACC_W          = 18;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [REG_IW-1:0] IX_S1_ENV  = 5'd2;
    localparam logic [REG_IW-1:0] IX_S1_FLO  = 5'd3;
    localparam logic [REG_IW-1:0] IX_S1_FHI  = 5'd4;
    localparam logic [REG_IW-1:0] IX_S2_ENV  = 5'd6;
    localparam logic [REG_IW-1:0] IX_S2_FLO  = 5'd7;
    localparam logic [REG_IW-1:0] IX_S2_FHI  = 5'd8;
    localparam logic [REG_IW-1:0] IX_W_ON    = 5'd9;
    localparam logic [REG_IW-1:0] IX_W_LEVEL = 5'd11;
    localparam logic [REG_IW-1:0] IX_W_FLO   = 5'd12;
    localparam logic [REG_IW-1:0] IX_W_FHI   = 5'd13;
    localparam logic [REG_IW-1:0] IX_N_LEN   = 5'd14;
    localparam logic [REG_IW-1:0] IX_N_ENV   = 5'd15;
    localparam logic [REG_IW-1:0] IX_N_POLY  = 5'd16;
    localparam logic [REG_IW-1:0] IX_N_CTRL  = 5'd17;

    localparam logic [1:0] CH_SQ1  = 2'd0;
    localparam logic [1:0] CH_SQ2  = 2'd1;
    localparam logic [1:0] CH_WAVE = 2'd2;

    localparam logic [1:0] LVL_ZERO = 2'd0;
    localparam logic [1:0] LVL_POS  = 2'd1;
    localparam logic [1:0] LVL_NEG  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       do_write;
        logic       tick_clear;
        logic       ch_start;
        logic       div_step;
        logic       ch_finish;
        logic       noise_start;
        logic       noise_step;
        logic       noise_finish;
        logic       len_update;
        logic       out_load;
        logic [1:0] ch;
    } fcsg_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       ch_en;
        logic       noise_en;
        logic       noise_audible;
        logic       timer_le0;
        logic       out_free;
    } fcsg_stat_t;

    // {valid, index}
    function automatic logic [REG_IW:0] reg_map(input logic [15:0] a);
        logic [REG_IW:0] r;
        r = '0;
        if (a >= 16'hFF10 && a <= 16'hFF14) r = {1'b1, 5'(a - 16'hFF10)};
        else if (a >= 16'hFF16 && a <= 16'hFF19) r = {1'b1, 5'(a - 16'hFF16 + 16'd5)};
        else if (a >= 16'hFF1A && a <= 16'hFF1E) r = {1'b1, 5'(a - 16'hFF1A + 16'd9)};
        else if (a >= 16'hFF20 && a <= 16'hFF23) r = {1'b1, 5'(a - 16'hFF20 + 16'd14)};
        return r;
    endfunction

    // floor(v*32767/60)
    function automatic logic [12:0] env_mag(input logic [3:0] v);
        logic [12:0] m;
        case (v)
            4'd0:    m = 13'd0;
            4'd1:    m = 13'd546;
            4'd2:    m = 13'd1092;
            4'd3:    m = 13'd1638;
            4'd4:    m = 13'd2184;
            4'd5:    m = 13'd2730;
            4'd6:    m = 13'd3276;
            4'd7:    m = 13'd3822;
            4'd8:    m = 13'd4368;
            4'd9:    m = 13'd4915;
            4'd10:   m = 13'd5461;
            4'd11:   m = 13'd6007;
            4'd12:   m = 13'd6553;
            4'd13:   m = 13'd7099;
            4'd14:   m = 13'd7645;
            default: m = 13'd8191;
        endcase
        return m;
    endfunction

    // wave table: +1, 0 or -1 as {neg, pos}
    function automatic logic [1:0] wave_val(input logic [WAVE_IW-1:0] i);
        logic [1:0] w;
        case (i)
            5'd1, 5'd5, 5'd8, 5'd9, 5'd10, 5'd15, 5'd20, 5'd21, 5'd22: w = 2'b01;
            5'd3, 5'd7, 5'd11, 5'd12, 5'd13, 5'd14, 5'd23, 5'd24, 5'd25,
            5'd26, 5'd27: w = 2'b10;
            default: w = 2'b00;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* sv/fcsg_dpath.sv */
`default_nettype none
module fcsg_dpath
    import fcsg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    input  wire fcsg_cmd_t   cmd,
    output fcsg_stat_t       stat
);

    logic [1:0]            cmd_reg;
    logic [15:0]           addr_reg;
    logic [7:0]            wdata_reg;
    logic [7:0]            regs_reg [0:REG_COUNT-1];
    logic [PHASE_BITS-1:0] phase_reg [0:2];
    logic signed [ACC_W-1:0]   acc_reg;
    logic [DIV_W-1:0]      d_reg;
    logic [DIV_W-1:0]      r_reg;
    logic [PHASE_BITS-1:0] q_reg;
    logic [14:0]           lfsr_reg;
    logic signed [TIMER_W-1:0] timer_reg;
    logic [1:0]            level_reg;
    logic [INC_W-1:0]      inc_reg;
    logic signed [LEN_W-1:0]   len_acc_reg;
    logic                  out_valid_reg;
    logic                  out_is_sample_reg;
    logic [7:0]            out_rdata_reg;
    logic [15:0]           out_sample_reg;

    logic [REG_IW:0]   map;
    logic [REG_IW-1:0] ix;
    logic [REG_IW-1:0] env_ix, flo_ix, fhi_ix;
    logic              ch_en;
    logic [10:0]       freq;
    logic [11:0]       span;
    logic [27:0]       prod;
    logic [12:0]       mag;
    logic [12:0]       scale;
    logic [1:0]        wv;
    logic signed [ACC_W-1:0] term;
    logic [27:0]       r2;
    logic              ge;
    logic [12:0]       nmag;
    logic              noise_en, noise_audible;
    logic [3:0]        kp1;
    logic [21:0]       base;
    logic              fb;
    logic [14:0]       lfsr_next;
    logic signed [LEN_W:0] len_next;
    logic [7:0]        rdata;
    logic signed [ACC_W-1:0] clamp;

    assign map    = reg_map(addr_reg);
    assign ix     = map[REG_IW-1:0];

    always_comb begin
        case (cmd.ch)
            CH_SQ1: begin
                env_ix = IX_S1_ENV; flo_ix = IX_S1_FLO; fhi_ix = IX_S1_FHI;
                ch_en  = regs_reg[IX_S1_FHI][7];
            end
            CH_SQ2: begin
                env_ix = IX_S2_ENV; flo_ix = IX_S2_FLO; fhi_ix = IX_S2_FHI;
                ch_en  = regs_reg[IX_S2_FHI][7];
            end
            default: begin
                env_ix = IX_W_LEVEL; flo_ix = IX_W_FLO; fhi_ix = IX_W_FHI;
                ch_en  = regs_reg[IX_W_ON][7];
            end
        endcase
    end

    assign freq  = {regs_reg[fhi_ix][2:0], regs_reg[flo_ix]};
    assign span  = 12'd2048 - {1'b0, freq};
    assign prod  = 28'(span) * 28'd44100;
    assign mag   = env_mag(regs_reg[env_ix][7:4]);
    assign scale = 13'd256 << regs_reg[IX_W_LEVEL][6:5];
    assign wv    = wave_val(phase_reg[CH_WAVE][PHASE_BITS-1 -: WAVE_IW]);

    always_comb begin
        term = '0;
        if (cmd.ch == CH_WAVE) begin
            if (regs_reg[IX_W_LEVEL][6:5] != 2'd0) begin
                if (wv[0])      term = ACC_W'(scale);
                else if (wv[1]) term = -ACC_W'(scale);
            end
        end else if (phase_reg[cmd.ch][PHASE_BITS-1]) begin
            term = ACC_W'(mag);
        end else begin
            term = -ACC_W'(mag);
        end
    end

    assign r2 = {r_reg, 1'b0};
    assign ge = r2 >= {1'b0, d_reg};

    assign nmag          = env_mag(regs_reg[IX_N_ENV][7:4]);
    assign noise_en      = regs_reg[IX_N_CTRL][7];
    assign noise_audible = noise_en && (nmag != 13'd0);
    assign kp1           = {1'b0, regs_reg[IX_N_POLY][6:4]} + 4'd1;
    assign base          = 22'd352800 * {18'd0, kp1};

    // 7-bit mode puts old bit 7 OR the feedback into bit 6
    assign fb = lfsr_reg[0] ^ lfsr_reg[1];
    always_comb begin
        if (regs_reg[IX_N_POLY][3]) begin
            lfsr_next = {fb, lfsr_reg[14:1]};
            if (lfsr_next == 15'd0) lfsr_next = 15'h7FFF;
        end else begin
            lfsr_next = {8'd0, lfsr_reg[7] | fb, lfsr_reg[6:1]};
            if (lfsr_next == 15'd0) lfsr_next = 15'h007F;
        end
    end

    assign len_next = LEN_W'(len_acc_reg) + (LEN_W+1)'(256);

    always_comb begin
        if (map[REG_IW] && ix == IX_N_CTRL) rdata = {regs_reg[IX_N_CTRL][7:6], regs_reg[IX_N_LEN][5:0]};
        else if (map[REG_IW])               rdata = regs_reg[ix];
        else                                rdata = 8'hFF;
    end

    always_comb begin
        if (acc_reg > 18'sd32767)        clamp = 18'sd32767;
        else if (acc_reg < -18'sd32768)  clamp = -18'sd32768;
        else                             clamp = acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) regs_reg[i] <= '0;
            for (int i = 0; i < 3; i++) phase_reg[i] <= '0;
            lfsr_reg      <= 15'h7FFF;
            timer_reg     <= '0;
            level_reg     <= LVL_ZERO;
            len_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                cmd_reg   <= s_tdata[1:0];
                addr_reg  <= s_tdata[17:2];
                wdata_reg <= s_tdata[25:18];
            end
            if (cmd.do_write && map[REG_IW]) begin
                regs_reg[ix] <= wdata_reg;
                if (ix == IX_S1_FHI && wdata_reg[7]) phase_reg[CH_SQ1] <= '0;
                if (ix == IX_S2_FHI && wdata_reg[7]) phase_reg[CH_SQ2] <= '0;
                if (ix == IX_N_CTRL && wdata_reg[7]) begin
                    regs_reg[IX_N_LEN] <= regs_reg[IX_N_LEN] & 8'h3F;
                    lfsr_reg  <= regs_reg[IX_N_POLY][3] ? 15'h7FFF : 15'h007F;
                    timer_reg <= '0;
                    level_reg <= LVL_ZERO;
                end
            end
            if (cmd.tick_clear) acc_reg <= '0;
            if (cmd.ch_start && ch_en) begin
                acc_reg <= acc_reg + term;
                d_reg   <= prod[DIV_W-1:0];
                r_reg   <= DIV_W'(1);
                q_reg   <= '0;
            end
            if (cmd.div_step) begin
                r_reg <= ge ? DIV_W'(r2 - {1'b0, d_reg}) : r2[DIV_W-1:0];
                q_reg <= {q_reg[PHASE_BITS-2:0], ge};
            end
            if (cmd.ch_finish) phase_reg[cmd.ch] <= phase_reg[cmd.ch] + q_reg;
            if (cmd.noise_start && noise_audible) begin
                timer_reg <= timer_reg - TIMER_W'(524288);
                inc_reg   <= INC_W'(base) << regs_reg[IX_N_POLY][2:0];
            end
            if (cmd.noise_step) begin
                lfsr_reg  <= lfsr_next;
                level_reg <= fb ? LVL_POS : LVL_NEG;
                timer_reg <= timer_reg + TIMER_W'(inc_reg);
            end
            if (cmd.noise_finish) begin
                if (level_reg == LVL_POS)      acc_reg <= acc_reg + ACC_W'(nmag);
                else if (level_reg == LVL_NEG) acc_reg <= acc_reg - ACC_W'(nmag);
            end
            if (cmd.len_update && regs_reg[IX_N_CTRL][6]) begin
                if (len_next >= 18'sd44100) begin
                    if (regs_reg[IX_N_LEN] == 8'd1) begin
                        // last count: noise switches off, length accumulator is set to -44100
                        regs_reg[IX_N_LEN]  <= 8'd0;
                        regs_reg[IX_N_CTRL] <= regs_reg[IX_N_CTRL] & 8'h3F;
                        timer_reg   <= '0;
                        level_reg   <= LVL_ZERO;
                        len_acc_reg <= -17'sd44100;
                    end else begin
                        len_acc_reg <= LEN_W'(len_next - 18'sd44100);
                        if (regs_reg[IX_N_LEN] != 8'd0)
                            regs_reg[IX_N_LEN] <= regs_reg[IX_N_LEN] - 8'd1;
                    end
                end else begin
                    len_acc_reg <= LEN_W'(len_next);
                end
            end
            if (cmd.out_load) begin
                out_valid_reg     <= 1'b1;
                out_is_sample_reg <= (cmd_reg == CMD_TICK);
                out_rdata_reg     <= (cmd_reg == CMD_TICK) ? 8'd0 : rdata;
                out_sample_reg    <= (cmd_reg == CMD_TICK) ? clamp[15:0] : 16'd0;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_sample_reg, out_rdata_reg, out_is_sample_reg};

    assign stat.cmd           = cmd_reg;
    assign stat.ch_en         = ch_en;
    assign stat.noise_en      = noise_en;
    assign stat.noise_audible = noise_audible;
    assign stat.timer_le0     = timer_reg[TIMER_W-1] || (timer_reg == '0);
    assign stat.out_free      = !out_valid_reg || m_tready;

endmodule
`default_nettype wire

/* sv/fcsg_ctrl.sv */
`default_nettype none
module fcsg_ctrl
    import fcsg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire fcsg_stat_t stat,
    output fcsg_cmd_t       cmd
);

    localparam int STEPS = PHASE_BITS + 17;
    localparam int CW    = $clog2(STEPS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_CH_START, ST_DIV, ST_CH_FIN,
        ST_N_START, ST_N_LOOP, ST_LEN, ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  ch_reg, ch_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb begin
        cmd        = '0;
        cmd.ch     = ch_reg;
        state_next = state_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.cmd)
                    CMD_READ:  state_next = ST_OUT;
                    CMD_WRITE: begin
                        cmd.do_write = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    CMD_TICK: begin
                        cmd.tick_clear = 1'b1;
                        ch_next        = CH_SQ1;
                        state_next     = ST_CH_START;
                    end
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_CH_START: begin
                cmd.ch_start = 1'b1;
                if (stat.ch_en) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else if (ch_reg == CH_WAVE) begin
                    state_next = ST_N_START;
                end else begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(STEPS - 1)) state_next = ST_CH_FIN;
                else cnt_next = cnt_reg + CW'(1);
            end
            ST_CH_FIN: begin
                cmd.ch_finish = 1'b1;
                if (ch_reg == CH_WAVE) begin
                    state_next = ST_N_START;
                end else begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_CH_START;
                end
            end
            ST_N_START: begin
                cmd.noise_start = 1'b1;
                if (!stat.noise_en)         state_next = ST_OUT;
                else if (stat.noise_audible) state_next = ST_N_LOOP;
                else                         state_next = ST_LEN;
            end
            ST_N_LOOP: begin
                if (stat.timer_le0) begin
                    cmd.noise_step = 1'b1;
                end else begin
                    cmd.noise_finish = 1'b1;
                    state_next       = ST_LEN;
                end
            end
            ST_LEN: begin
                cmd.len_update = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_SQ1;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

/* sv/four_channel_sound_generator.sv */
// Read request: decoded, then registered as a result once the output is free; write: no result.
// Tick request: the shared one-bit-per-cycle divider runs once per enabled channel in turn,
// plus at most two noise steps.
// One request is in flight at a time; the next is taken once the result is registered or the write is done.
// Reset (aresetn low, synchronous) clears all sound registers, phases, the noise timer and
// the length counter, and loads the noise LFSR with all ones.
`default_nettype none
module four_channel_sound_generator
    import fcsg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cmd[1:0], address[17:2], write_data[25:18]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // is_sample[0], read_data[8:1], sample[24:9]
);

    fcsg_cmd_t  cmd;
    fcsg_stat_t stat;

    // sequencer: walks the channels, divider iterations and noise steps
    fcsg_ctrl #(.PHASE_BITS(PHASE_BITS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // register file, phase accumulators, divider, noise and mixer
    fcsg_dpath #(.PHASE_BITS(PHASE_BITS)) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef NO_ASSERTIONS
    // an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // sample results carry no read byte
    a_sample_no_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[8:1] == 8'd0))
        else $error("sample result with read data");

    // read results carry no sample
    a_read_no_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[24:9] == 16'd0))
        else $error("read result with sample data");
`endif

endmodule
`default_nettype wire
